[rtl/core/pde_pkg.sv]
// ----------------------------------------------------------------------------
// pde_pkg
// Shared types, constants and helpers of the pack delta instruction encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pde_pkg;

  localparam int unsigned MaxBytes = 8;
  localparam int unsigned IdxW     = $clog2(MaxBytes);

  localparam logic [6:0]  ChunkMax       = 7'd127;
  localparam logic [23:0] CopyDefaultLen = 24'h010000;
  localparam logic [7:0]  CopyOpFlag     = 8'h80;

  typedef enum logic [1:0] {
    OpSize     = 2'd0,
    OpCopy     = 2'd1,
    OpInsStart = 2'd2,
    OpInsData  = 2'd3
  } op_e;

  // One encoded item: up to eight stream bytes.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [IdxW-1:0]          last_idx;
    logic                     fin;
    logic                     misuse;
  } item_t;

  function automatic logic [6:0] chunk_of(input logic [31:0] remaining);
    logic [6:0] c;
    if (remaining > {25'd0, ChunkMax}) begin
      c = ChunkMax;
    end else begin
      c = remaining[6:0];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/pde_encode.sv]
// ----------------------------------------------------------------------------
// pde_encode
// Encodes one delta item into its stream bytes and keeps the insert state.
// ----------------------------------------------------------------------------
`default_nettype none

module pde_encode (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [1:0]          operation_i,
  input  wire logic [31:0]         value_i,
  input  wire logic [23:0]         copy_length_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                final_req_i,
  output pde_pkg::item_t           item_o,
  output logic                     emit_o
);

  logic [31:0] rem_q, rem_d;
  logic [6:0]  cl_q, cl_d;

  logic [34:0] vx;
  logic [31:0] clx;
  logic [2:0]  var_last;
  logic [2:0]  ofs_last;
  logic [2:0]  len_n;
  logic [2:0]  kk;
  logic [2:0]  jj;
  logic [31:0] rem_n;
  logic [6:0]  cl_n;
  logic [6:0]  chunk;
  pde_pkg::op_e op;

  assign vx  = {3'd0, value_i};
  assign clx = {8'd0, copy_length_i};
  assign op  = pde_pkg::op_e'(operation_i);

  always_comb begin
    item_o   = '0;
    emit_o   = 1'b0;
    rem_d    = rem_q;
    cl_d     = cl_q;
    var_last = 3'd0;
    ofs_last = 3'd0;
    len_n    = 3'd0;
    kk       = 3'd0;
    jj       = 3'd0;
    rem_n    = rem_q - 32'd1;
    cl_n     = cl_q - 7'd1;
    chunk    = 7'd0;
    item_o.fin = final_req_i;
    case (op)
      pde_pkg::OpSize: begin
        rem_d  = '0;
        cl_d   = '0;
        emit_o = 1'b1;
        if (|value_i[31:28]) begin
          var_last = 3'd4;
        end else if (|value_i[31:21]) begin
          var_last = 3'd3;
        end else if (|value_i[31:14]) begin
          var_last = 3'd2;
        end else if (|value_i[31:7]) begin
          var_last = 3'd1;
        end
        for (int k = 0; k < 5; k++) begin
          item_o.bytes[k] = {(3'(k) < var_last), vx[7*k +: 7]};
        end
        item_o.last_idx = var_last;
      end
      pde_pkg::OpCopy: begin
        rem_d  = '0;
        cl_d   = '0;
        emit_o = 1'b1;
        if (|value_i[31:24]) begin
          ofs_last = 3'd3;
        end else if (|value_i[31:16]) begin
          ofs_last = 3'd2;
        end else if (|value_i[31:8]) begin
          ofs_last = 3'd1;
        end
        if (copy_length_i != pde_pkg::CopyDefaultLen) begin
          if (|copy_length_i[23:16]) begin
            len_n = 3'd3;
          end else if (|copy_length_i[23:8]) begin
            len_n = 3'd2;
          end else if (|copy_length_i[7:0]) begin
            len_n = 3'd1;
          end
        end
        item_o.bytes[0] = pde_pkg::CopyOpFlag;
        for (int i = 0; i < 4; i++) begin
          item_o.bytes[0][i] = (3'(i) <= ofs_last);
        end
        for (int j = 0; j < 3; j++) begin
          item_o.bytes[0][4+j] = (3'(j) < len_n);
        end
        for (int k = 1; k < 8; k++) begin
          kk = 3'(k - 1);
          jj = kk - ofs_last - 3'd1;
          if (kk <= ofs_last) begin
            item_o.bytes[k] = value_i[8*kk[1:0] +: 8];
          end else if (jj < len_n) begin
            item_o.bytes[k] = clx[8*jj[1:0] +: 8];
          end
        end
        item_o.last_idx = ofs_last + len_n + 3'd1;
      end
      pde_pkg::OpInsStart: begin
        rem_d = value_i;
        cl_d  = '0;
        if (value_i != '0) begin
          chunk           = pde_pkg::chunk_of(value_i);
          emit_o          = 1'b1;
          item_o.bytes[0] = {1'b0, chunk};
          cl_d            = chunk;
        end
      end
      pde_pkg::OpInsData: begin
        emit_o = 1'b1;
        if (rem_q == '0) begin
          item_o.misuse = 1'b1;
        end else begin
          item_o.bytes[0] = data_byte_i;
          rem_d = rem_n;
          if (rem_n == '0) begin
            cl_d = '0;
          end else if (cl_n == '0) begin
            chunk           = pde_pkg::chunk_of(rem_n);
            item_o.bytes[1] = {1'b0, chunk};
            item_o.last_idx = 3'd1;
            cl_d            = chunk;
          end else begin
            cl_d = cl_n;
          end
        end
      end
      default: begin
        emit_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      cl_q  <= '0;
    end else if (accept_i) begin
      rem_q <= rem_d;
      cl_q  <= cl_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/pde_serialize.sv]
// ----------------------------------------------------------------------------
// pde_serialize
// Holding register plus byte shifter: emits an encoded item one beat per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pde_serialize (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire pde_pkg::item_t item_i,
  output logic                busy_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                last_of_item_o,
  output logic                end_of_delta_o,
  output logic                misuse_o
);

  pde_pkg::item_t              a_q, b_q;
  logic                        a_valid_q, b_valid_q;
  logic [pde_pkg::IdxW-1:0]    idx_q;
  logic                        b_last;
  logic                        b_pop;
  logic                        b_done;
  logic                        a_move;

  assign b_last = (idx_q == b_q.last_idx);
  assign b_pop  = b_valid_q && !out_stall_i;
  assign b_done = b_pop && b_last;
  assign a_move = a_valid_q && (!b_valid_q || b_done);
  assign busy_o = a_valid_q && !a_move;

  assign out_valid_o    = b_valid_q;
  assign out_byte_o     = b_q.bytes[idx_q];
  assign last_of_item_o = b_last;
  assign end_of_delta_o = b_last && b_q.fin;
  assign misuse_o       = b_q.misuse;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      if (load_i) begin
        a_valid_q <= 1'b1;
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end
      if (a_move) begin
        b_valid_q <= 1'b1;
        idx_q     <= '0;
      end else if (b_done) begin
        b_valid_q <= 1'b0;
        idx_q     <= '0;
      end else if (b_pop) begin
        idx_q <= idx_q + {{(pde_pkg::IdxW-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      a_q <= item_i;
    end
    if (a_move) begin
      b_q <= a_q;
    end
  end

endmodule

`default_nettype wire

[rtl/core/pack_delta_instruction_encoder.sv]
// ----------------------------------------------------------------------------
// pack_delta_instruction_encoder
// Serializes delta items (sizes, copies, inserts) into the pack delta stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one item per beat: a size
//   varint, a copy instruction, an insert start or one insert data byte.
//   Output channel (out_valid_o / out_stall_i) gives one stream byte per beat,
//   with last_of_item_o on the final byte of an item and end_of_delta_o on
//   the final byte of an item marked final_req_i.
//   An item is encoded in the cycle it is accepted and sits in a holding
//   register; its first byte appears once it moves into the output register.
//   Throughput: one output byte per cycle while the receiver does not stall.
//   An item has one byte for an insert start or a plain data byte, two for
//   a data byte that closes a chunk with more to come, 1-5 for a size and
//   2-8 for a copy. An insert start of length zero produces no beat.
//   Reset clears the insert state and empties the holding and output registers.
//   While the receiver stalls, the current byte holds and one further item
//   is taken into the holding register before in_stall_o rises.
// ----------------------------------------------------------------------------
`default_nettype none

module pack_delta_instruction_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [31:0] value_i,
  input  wire logic [23:0] copy_length_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        final_req_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_of_item_o,
  output logic             end_of_delta_o,
  output logic             misuse_o
);

  pde_pkg::item_t enc_item;
  logic           enc_emit;
  logic           accept;
  logic           busy;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  pde_encode u_encode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .operation_i   (operation_i),
    .value_i       (value_i),
    .copy_length_i (copy_length_i),
    .data_byte_i   (data_byte_i),
    .final_req_i   (final_req_i),
    .item_o        (enc_item),
    .emit_o        (enc_emit)
  );

  pde_serialize u_serialize (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept && enc_emit),
    .item_i         (enc_item),
    .busy_o         (busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_of_item_o (last_of_item_o),
    .end_of_delta_o (end_of_delta_o),
    .misuse_o       (misuse_o)
  );

endmodule

`default_nettype wire

[rtl/core/pde_checker.sv]
// ----------------------------------------------------------------------------
// pde_checker
// Port-level checks of the pack delta instruction encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module pde_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  operation_i,
  input wire logic [31:0] value_i,
  input wire logic [23:0] copy_length_i,
  input wire logic [7:0]  data_byte_i,
  input wire logic        final_req_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  out_byte_o,
  input wire logic        last_of_item_o,
  input wire logic        end_of_delta_o,
  input wire logic        misuse_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(last_of_item_o) && $stable(end_of_delta_o))
    else $error("stalled output beat changed");

  a_misuse_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && misuse_o |-> last_of_item_o && (out_byte_o == 8'd0))
    else $error("misuse beat is not a single zero byte");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_delta_o |-> last_of_item_o)
    else $error("end of delta on a non-final byte");

  a_idle_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("busy right after reset");

endmodule

bind pack_delta_instruction_encoder pde_checker u_pde_checker (.*);

`default_nettype wire

[tb/sv/pde_stream_check_pkg.sv]
// ----------------------------------------------------------------------------
// pde_stream_check_pkg
// Expected-byte tracker for the pack delta instruction encoder test: encodes
// every accepted item into the bytes it should produce and checks each output
// beat against the oldest one still waiting.
// ----------------------------------------------------------------------------
package pde_stream_check_pkg;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eod;
    logic       mis;
  } stream_beat_t;

  class delta_stream_checker;

    stream_beat_t expected_bytes[$];
    logic [31:0]  ins_left;
    logic [6:0]   chunk_left;
    int           mismatches;

    function new();
      ins_left   = '0;
      chunk_left = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function logic [7:0] open_chunk();
      logic [6:0] c;
      c = (ins_left < 32'(pde_pkg::ChunkMax)) ? ins_left[6:0] : pde_pkg::ChunkMax;
      chunk_left = c;
      return {1'b0, c};
    endfunction

    // Encode one accepted item and queue the bytes it must produce.
    function void note_item(pde_pkg::op_e op, logic [31:0] value, logic [23:0] clen,
                            logic [7:0] db, logic fin);
      logic [7:0]  enc [8];
      logic [31:0] v;
      logic [23:0] l;
      int          n;
      logic        mis;
      n   = 0;
      mis = 1'b0;
      v   = value;
      l   = clen;
      case (op)
        pde_pkg::OpSize: begin
          ins_left   = '0;
          chunk_left = '0;
          enc[0] = {1'b0, v[6:0]};
          n = 1;
          v = v >> 7;
          while (v != 0) begin
            enc[n-1][7] = 1'b1;
            enc[n] = {1'b0, v[6:0]};
            n++;
            v = v >> 7;
          end
        end
        pde_pkg::OpCopy: begin
          ins_left   = '0;
          chunk_left = '0;
          enc[0] = pde_pkg::CopyOpFlag;
          n = 1;
          for (int i = 0; i < 4; i++) begin
            enc[0][i] = 1'b1;
            enc[n] = v[7:0];
            n++;
            v = v >> 8;
            if (v == 0) break;
          end
          if (l != pde_pkg::CopyDefaultLen) begin
            for (int i = 0; i < 3 && l != 0; i++) begin
              enc[0][i+4] = 1'b1;
              enc[n] = l[7:0];
              n++;
              l = l >> 8;
            end
          end
        end
        pde_pkg::OpInsStart: begin
          ins_left   = value;
          chunk_left = '0;
          if (ins_left != 0) begin
            enc[0] = open_chunk();
            n = 1;
          end
        end
        default: begin
          if (ins_left == 0) begin
            enc[0] = 8'h00;
            mis = 1'b1;
            n = 1;
          end else begin
            enc[0] = db;
            n = 1;
            ins_left   = ins_left - 32'd1;
            chunk_left = chunk_left - 7'd1;
            if (ins_left == 0) begin
              chunk_left = '0;
            end else if (chunk_left == 0) begin
              enc[1] = open_chunk();
              n = 2;
            end
          end
        end
      endcase
      for (int k = 0; k < n; k++) begin
        expected_bytes.push_back('{enc[k], k == n - 1, (k == n - 1) && fin, mis});
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic eod, logic mis);
      stream_beat_t exp_b;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected beat: byte %02h last %0b end %0b misuse %0b",
                   data, last, eod, mis);
        end
        return;
      end
      exp_b = expected_bytes.pop_front();
      if (exp_b.data !== data || exp_b.last !== last || exp_b.eod !== eod ||
          exp_b.mis !== mis) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                   exp_b.data, exp_b.last, exp_b.eod, exp_b.mis,
                   data, last, eod, mis);
        end
      end
    endfunction

  endclass

endpackage

[tb/sv/pack_delta_instruction_encoder_test.sv]
// ----------------------------------------------------------------------------
// pack_delta_instruction_encoder_test
// Drives sizes, copies and insert runs into the encoder with random gaps and
// output stalls, and checks every stream byte against a behavioral encoder.
// ----------------------------------------------------------------------------
module pack_delta_instruction_encoder_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int RandItems  = 400;

  typedef struct {
    pde_pkg::op_e op;
    logic [31:0]  value;
    logic [23:0]  clen;
    logic [7:0]   db;
    logic         fin;
  } delta_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  operation_i;
  logic [31:0] value_i;
  logic [23:0] copy_length_i;
  logic [7:0]  data_byte_i;
  logic        final_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte_o;
  logic        last_of_item_o;
  logic        end_of_delta_o;
  logic        misuse_o;

  pde_stream_check_pkg::delta_stream_checker stream_chk;
  int   cycles;
  int   items_sent;
  int   stall_left;
  logic burst;

  pack_delta_instruction_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .value_i       (value_i),
    .copy_length_i (copy_length_i),
    .data_byte_i   (data_byte_i),
    .final_req_i   (final_req_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_item_o(last_of_item_o),
    .end_of_delta_o(end_of_delta_o),
    .misuse_o      (misuse_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic delta_item_t mk(pde_pkg::op_e op, logic [31:0] value,
                                     logic [23:0] clen, logic [7:0] db, logic fin);
    delta_item_t it;
    it.op    = op;
    it.value = value;
    it.clen  = clen;
    it.db    = db;
    it.fin   = fin;
    return it;
  endfunction

  // Random value with a random top bit position, so short encodings are common.
  function automatic logic [31:0] rand_value();
    int          w;
    logic [31:0] v;
    w = $urandom_range(1, 32);
    v = $urandom;
    if (w < 32) v = v & ((32'd1 << w) - 32'd1);
    return v;
  endfunction

  function automatic logic [23:0] rand_clen();
    logic [23:0] l;
    case ($urandom_range(0, 5))
      0: l = '0;
      1: l = pde_pkg::CopyDefaultLen;
      default: l = 24'(rand_value() >> 8);
    endcase
    return l;
  endfunction

  function automatic logic rand_fin();
    return $urandom_range(0, 7) == 0;
  endfunction

  task automatic send_item(input delta_item_t it);
    int gap;
    if ($urandom_range(0, 29) == 0) burst = ~burst;
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= it.op;
    value_i       <= it.value;
    copy_length_i <= it.clen;
    data_byte_i   <= it.db;
    final_req_i   <= it.fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    stream_chk.note_item(it.op, it.value, it.clen, it.db, it.fin);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (stream_chk.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_insert_run();
    int len;
    int cut;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(120, 260) : $urandom_range(1, 40);
    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : len;
    send_item(mk(pde_pkg::OpInsStart, 32'(len), 24'($urandom), 8'($urandom), rand_fin()));
    for (int k = 0; k < cut && items_sent < RandItems; k++) begin
      send_item(mk(pde_pkg::OpInsData, $urandom, 24'($urandom),
                   8'($urandom_range(0, 255)), rand_fin()));
    end
  endtask

  // Output side: random stall before each beat, none in burst stretches.
  initial begin
    stall_left  = 0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        stream_chk.check_byte(out_byte_o, last_of_item_o, end_of_delta_o, misuse_o);
        stall_left = burst ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int   waited;
    logic drained;
    stream_chk    = new();
    items_sent    = 0;
    burst         = 1'b0;
    drained       = 1'b0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    operation_i   <= pde_pkg::OpSize;
    value_i       <= '0;
    copy_length_i <= '0;
    data_byte_i   <= '0;
    final_req_i   <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_item(mk(pde_pkg::OpSize, 32'h0, 24'h0, 8'h00, 1'b0));
    send_item(mk(pde_pkg::OpSize, 32'h7f, 24'h0, 8'h00, 1'b0));
    send_item(mk(pde_pkg::OpSize, 32'h80, 24'h0, 8'h00, 1'b0));
    send_item(mk(pde_pkg::OpSize, 32'hffffffff, 24'hffffff, 8'hff, 1'b0));
    send_item(mk(pde_pkg::OpCopy, 32'h0, 24'h0, 8'h00, 1'b0));
    send_item(mk(pde_pkg::OpCopy, 32'hffffffff, 24'hffffff, 8'h00, 1'b0));
    send_item(mk(pde_pkg::OpCopy, 32'h12, pde_pkg::CopyDefaultLen, 8'h00, 1'b0));
    send_item(mk(pde_pkg::OpCopy, 32'h00010000, 24'h000100, 8'h00, 1'b1));
    send_item(mk(pde_pkg::OpInsData, 32'h0, 24'h0, 8'hff, 1'b1));
    send_item(mk(pde_pkg::OpInsStart, 32'h0, 24'h0, 8'h00, 1'b1));
    send_item(mk(pde_pkg::OpInsStart, 32'h2, 24'h0, 8'h00, 1'b0));
    send_item(mk(pde_pkg::OpInsData, 32'h0, 24'h0, 8'h00, 1'b0));
    send_item(mk(pde_pkg::OpInsStart, 32'h5, 24'h0, 8'h00, 1'b0));
    send_item(mk(pde_pkg::OpInsData, 32'h0, 24'h0, 8'hff, 1'b0));
    send_item(mk(pde_pkg::OpSize, 32'h1, 24'h0, 8'h00, 1'b0));
    send_item(mk(pde_pkg::OpInsStart, 32'h3, 24'h0, 8'h00, 1'b0));
    send_item(mk(pde_pkg::OpInsData, 32'h0, 24'h0, 8'ha5, 1'b0));
    send_item(mk(pde_pkg::OpCopy, 32'h1, 24'h1, 8'h00, 1'b0));
    send_item(mk(pde_pkg::OpInsData, 32'h0, 24'h0, 8'h5a, 1'b0));
    send_item(mk(pde_pkg::OpInsStart, 32'h1, 24'h0, 8'h00, 1'b0));
    send_item(mk(pde_pkg::OpInsData, 32'h0, 24'h0, 8'h3c, 1'b1));
    send_item(mk(pde_pkg::OpInsStart, 32'hffffffff, 24'h0, 8'h00, 1'b0));
    send_item(mk(pde_pkg::OpInsData, 32'h0, 24'h0, 8'h81, 1'b0));
    send_item(mk(pde_pkg::OpSize, 32'h0fffffff, 24'h0, 8'h00, 1'b1));

    // random part
    while (items_sent < RandItems) begin
      if (!drained && items_sent >= RandItems / 2) begin
        drain();
        drained = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1: send_item(mk(pde_pkg::OpSize, rand_value(), 24'($urandom), 8'($urandom),
                           rand_fin()));
        2, 3: send_item(mk(pde_pkg::OpCopy, rand_value(), rand_clen(), 8'($urandom),
                           rand_fin()));
        8: send_item(mk(pde_pkg::OpInsData, $urandom, 24'($urandom), 8'($urandom),
                        rand_fin()));
        9: send_item(mk(pde_pkg::OpInsStart,
                        ($urandom_range(0, 1) == 0) ? 32'h0 : rand_value(),
                        24'($urandom), 8'($urandom), rand_fin()));
        default: send_insert_run();
      endcase
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (stream_chk.pending() != 0) @(posedge clk_i);
    for (waited = 0; waited < 20; waited++) @(posedge clk_i);
    if (stream_chk.mismatches == 0 && stream_chk.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
